// ===== design/esbl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Erase-scan block list builder package
// Shared widths, codes, state encoding and controller/datapath interfaces.
// ---------------------------------------------------------------------------
package esbl_pkg;

	localparam int IDX_W = 12;
	localparam int PTR_W = 13;
	localparam int CNT_W = 12;

	localparam logic [PTR_W-1:0] NONE_PTR  = 13'd4096;
	localparam logic [CNT_W-1:0] COUNT_MAX = 12'd4095;
	localparam logic [CNT_W-1:0] QUOTA_RST = 12'd4095;

	typedef enum logic [1:0] {
		VERDICT_NONE = 2'd0,
		VERDICT_FREE = 2'd1,
		VERDICT_BAD  = 2'd2,
		VERDICT_READ = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_FREE    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_WRITE,
		ST_RDWAIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic clear;
		logic exec;
		logic fin;
		logic rd_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_read;
		logic append;
		logic clear_last;
	} dp_status_t;

endpackage

// ===== design/esbl_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One read or write port, registered read data, no reset on the array.
// ---------------------------------------------------------------------------
module esbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/esbl_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Erase-scan block list builder controller
// Sequences the clearing pass, request execution and the table writes.
// ---------------------------------------------------------------------------
module esbl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  esbl_pkg::dp_status_t status,
	output esbl_pkg::ctrl_cmd_t  cmd
);
	import esbl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE, ST_WRITE, ST_RDWAIT: begin
				state_d = start ? ST_EXEC : ST_IDLE;
			end
			ST_EXEC: begin
				if (status.req_read)    state_d = ST_RDWAIT;
				else if (status.append) state_d = ST_WRITE;
				else                    state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		busy       = (state_q == ST_CLEAR) || (state_q == ST_EXEC);
		cmd.accept = start && !busy;
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.exec   = (state_q == ST_EXEC);
		cmd.fin    = (state_q == ST_WRITE);
		cmd.rd_out = (state_q == ST_RDWAIT);
	end

endmodule

// ===== design/esbl_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Erase-scan block list builder datapath
// Holds the request, list ends, counters, block tables and result registers.
// ---------------------------------------------------------------------------
module esbl_datapath #(
	parameter int DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  esbl_pkg::ctrl_cmd_t           cmd,
	output esbl_pkg::dp_status_t          status,
	input  logic                          cfg_we,
	input  logic [esbl_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                          req_type,
	input  logic [esbl_pkg::IDX_W-1:0]    block_index,
	input  logic                          erase_failed,
	input  logic                          last_die,
	output logic                          done,
	output logic [1:0]                    verdict,
	output logic [esbl_pkg::PTR_W-1:0]    next_pointer,
	output logic [1:0]                    block_kind,
	output logic [esbl_pkg::PTR_W-1:0]    free_head,
	output logic [esbl_pkg::PTR_W-1:0]    free_tail,
	output logic [esbl_pkg::PTR_W-1:0]    bad_head,
	output logic [esbl_pkg::PTR_W-1:0]    bad_tail,
	output logic [esbl_pkg::CNT_W-1:0]    free_total,
	output logic                          quota_reached
);
	import esbl_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(DEPTH);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

	// Latched request.
	logic             req_q;
	logic [IDX_W-1:0] blk_q;
	logic             failed_q;
	logic             last_q;

	// Scan state.
	logic [CNT_W-1:0] quota_q;
	logic             acc_q;
	logic [PTR_W-1:0] free_first_q, free_last_q, bad_first_q, bad_last_q;
	logic [CNT_W-1:0] count_q;
	logic             qflag_q;

	// Table write bookkeeping and read qualifiers.
	logic             mark_q;
	kind_t            kind_val_q;
	logic             oor_q;
	logic [AW-1:0]    clr_cnt_q;

	// Result registers.
	logic             done_q;
	verdict_t         verdict_q;
	logic [PTR_W-1:0] next_q;
	logic [1:0]       kind_q;
	logic [PTR_W-1:0] fh_q, ft_q, bh_q, bt_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic             qflag_out_q;

	// Next-state values of one report.
	logic             in_rng, valid_rep, acc_new, append, go_free;
	logic [PTR_W-1:0] cur_tail, blk_ptr;
	logic [PTR_W-1:0] ff_d, fl_d, bf_d, bl_d;
	logic [CNT_W-1:0] cnt_d;
	logic             qflag_d, acc_d;
	verdict_t         verdict_d;

	// Memory ports.
	logic             link_we, kind_we;
	logic [AW-1:0]    link_addr, kind_addr;
	logic [PTR_W-1:0] link_wdata, link_rdata;
	logic [1:0]       kind_wdata, kind_rdata;

	always_comb begin
		blk_ptr   = {1'b0, blk_q};
		in_rng    = blk_ptr < DEPTH_PTR;
		valid_rep = !req_q && (blk_q != '0) && in_rng;
		acc_new   = acc_q && !failed_q;
		append    = valid_rep && last_q;
		go_free   = !qflag_q && acc_new;
		cur_tail  = go_free ? free_last_q : bad_last_q;

		ff_d      = free_first_q;
		fl_d      = free_last_q;
		bf_d      = bad_first_q;
		bl_d      = bad_last_q;
		cnt_d     = count_q;
		qflag_d   = qflag_q;
		acc_d     = acc_q;
		verdict_d = VERDICT_NONE;

		if (valid_rep) begin
			acc_d = last_q ? 1'b1 : acc_new;
		end
		if (append) begin
			if (go_free) begin
				verdict_d = VERDICT_FREE;
				if (count_q != COUNT_MAX) cnt_d = count_q + 1'b1;
				if (free_first_q == NONE_PTR) ff_d = blk_ptr;
				fl_d = blk_ptr;
			end else begin
				verdict_d = VERDICT_BAD;
				if (bad_first_q == NONE_PTR) bf_d = blk_ptr;
				bl_d = blk_ptr;
			end
			if (!qflag_q && (cnt_d >= quota_q)) qflag_d = 1'b1;
		end
	end

	always_comb begin
		status.req_read   = req_q;
		status.append     = append;
		status.clear_last = (clr_cnt_q == LAST_ADDR);
	end

	// Link table: the old tail's link is written while the request executes,
	// the new block's link in the following cycle, so a block relinked onto
	// itself ends with no successor.
	always_comb begin
		link_we    = (cmd.exec && append && (cur_tail != NONE_PTR)) || cmd.fin;
		link_addr  = (cmd.exec && append) ? cur_tail[AW-1:0] : blk_q[AW-1:0];
		link_wdata = cmd.exec ? blk_ptr : NONE_PTR;
		kind_we    = cmd.clear || (cmd.fin && mark_q);
		kind_addr  = cmd.clear ? clr_cnt_q : blk_q[AW-1:0];
		kind_wdata = cmd.clear ? KIND_UNKNOWN : kind_val_q;
	end

	esbl_ram #(.WIDTH(PTR_W), .DEPTH(DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.addr  (link_addr),
		.wdata (link_wdata),
		.rdata (link_rdata)
	);

	esbl_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_kind_ram (
		.clk   (clk),
		.we    (kind_we),
		.addr  (kind_addr),
		.wdata (kind_wdata),
		.rdata (kind_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q    <= req_type;
			blk_q    <= block_index;
			failed_q <= erase_failed;
			last_q   <= last_die;
		end
		if (cmd.exec) begin
			mark_q     <= append && !qflag_q;
			kind_val_q <= go_free ? KIND_FREE : KIND_BAD;
			oor_q      <= !in_rng;
		end
		if (cmd.exec && !req_q) begin
			verdict_q   <= verdict_d;
			next_q      <= '0;
			kind_q      <= KIND_UNKNOWN;
			fh_q        <= ff_d;
			ft_q        <= fl_d;
			bh_q        <= bf_d;
			bt_q        <= bl_d;
			cnt_out_q   <= cnt_d;
			qflag_out_q <= qflag_d;
		end else if (cmd.rd_out) begin
			verdict_q   <= VERDICT_READ;
			next_q      <= oor_q ? NONE_PTR : link_rdata;
			kind_q      <= oor_q ? KIND_UNKNOWN : kind_rdata;
			fh_q        <= free_first_q;
			ft_q        <= free_last_q;
			bh_q        <= bad_first_q;
			bt_q        <= bad_last_q;
			cnt_out_q   <= count_q;
			qflag_out_q <= qflag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q      <= QUOTA_RST;
			acc_q        <= 1'b1;
			free_first_q <= NONE_PTR;
			free_last_q  <= NONE_PTR;
			bad_first_q  <= NONE_PTR;
			bad_last_q   <= NONE_PTR;
			count_q      <= '0;
			qflag_q      <= 1'b0;
			clr_cnt_q    <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_we) quota_q <= cfg_wdata;
			if (cmd.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.exec) begin
				acc_q        <= acc_d;
				free_first_q <= ff_d;
				free_last_q  <= fl_d;
				bad_first_q  <= bf_d;
				bad_last_q   <= bl_d;
				count_q      <= cnt_d;
				qflag_q      <= qflag_d;
			end
			done_q <= (cmd.exec && !req_q) || cmd.rd_out;
		end
	end

	assign done          = done_q;
	assign verdict       = verdict_q;
	assign next_pointer  = next_q;
	assign block_kind    = kind_q;
	assign free_head     = fh_q;
	assign free_tail     = ft_q;
	assign bad_head      = bh_q;
	assign bad_tail      = bt_q;
	assign free_total    = cnt_out_q;
	assign quota_reached = qflag_out_q;

endmodule

// ===== design/erase_scan_block_list_builder_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Erase-scan block list builder
// Folds per-die erase reports into free and bad block lists kept as links in
// a block table, and answers reads of single table entries.
// ---------------------------------------------------------------------------
// A request is presented on req_type, block_index, erase_failed and last_die
// and is taken at a rising edge where start is high and busy is low. Every
// request produces exactly one result, shown on the result ports for one
// cycle while done is high; the receiver cannot stall, so a result must be
// captured in that cycle.
// The result of a report is registered at the end of its execute cycle. A
// read then waits in the read-wait state for the registered memory data, and
// its result is registered from that data. A new request cannot be taken in
// the execute cycle that follows a taken request; busy is high there and,
// outside the clearing pass, only there. The link memory is single-port: it
// takes the old tail's link in the execute cycle and the new block's link in
// the cycle after it.
// After reset deasserts, the block runs a clearing pass over the block-type
// memory, one entry per cycle over min(BLOCK_COUNT, 4096) entries, with busy
// high. The link memory is not cleared. The quota register (cfg_we,
// cfg_wdata) resets to 4095 and may be written in any cycle, including
// during the clearing pass; it should only change while no request is open.
// ---------------------------------------------------------------------------
module erase_scan_block_list_builder_top #(
	parameter int BLOCK_COUNT = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cfg_we,
	input  logic [esbl_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                       req_type,
	input  logic [esbl_pkg::IDX_W-1:0] block_index,
	input  logic                       erase_failed,
	input  logic                       last_die,
	output logic                       done,
	output logic [1:0]                 verdict,
	output logic [esbl_pkg::PTR_W-1:0] next_pointer,
	output logic [1:0]                 block_kind,
	output logic [esbl_pkg::PTR_W-1:0] free_head,
	output logic [esbl_pkg::PTR_W-1:0] free_tail,
	output logic [esbl_pkg::PTR_W-1:0] bad_head,
	output logic [esbl_pkg::PTR_W-1:0] bad_tail,
	output logic [esbl_pkg::CNT_W-1:0] free_total,
	output logic                       quota_reached
);
	import esbl_pkg::*;

	// Block indices are 12 bits wide, so no more than 4096 table entries can
	// ever be addressed; larger block counts keep a 4096-entry table.
	localparam int DEPTH = (BLOCK_COUNT < 4096) ? BLOCK_COUNT : 4096;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// The controller owns sequencing; the datapath owns the rest of the state.
	esbl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	esbl_datapath #(.DEPTH(DEPTH)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_type      (req_type),
		.block_index   (block_index),
		.erase_failed  (erase_failed),
		.last_die      (last_die),
		.done          (done),
		.verdict       (verdict),
		.next_pointer  (next_pointer),
		.block_kind    (block_kind),
		.free_head     (free_head),
		.free_tail     (free_tail),
		.bad_head      (bad_head),
		.bad_tail      (bad_tail),
		.free_total    (free_total),
		.quota_reached (quota_reached)
	);

endmodule
